// ===== hw/rtl/cas_pkg.sv =====
package cas_pkg;

   // Sizing of the alarm table and the per-advance fire cap.
   localparam int NUM_ALARMS = 16;
   localparam int MAX_FIRES  = 16;

   localparam int IDX_W  = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int SCAN_W = $clog2(NUM_ALARMS + 1);
   localparam int FIRE_W = $clog2(MAX_FIRES + 1);

   // Field widths of the channels.
   localparam int OPCODE_W    = 2;
   localparam int STEP_W      = 24;
   localparam int INDEX_W     = 4;
   localparam int TICKS_W     = 16;
   localparam int ALARM_OUT_W = 4;
   localparam int COUNT_W     = 5;

   // Configuration port and register widths.
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 24;
   localparam int ALARM_COUNT_W = 5;
   localparam int MASK_W        = 16;
   localparam int REANCHOR_W    = 24;

   // Time arithmetic.
   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 30;
   localparam int TICK_W   = 14;
   localparam int ENTRY_W  = PERIOD_W + TIME_W;

   localparam logic [TICK_W-1:0]     TICK_US        = 14'd10000;
   localparam logic [STEP_W-1:0]     STEP_CLAMP_US  = 24'd1000000;
   localparam logic [REANCHOR_W-1:0] REANCHOR_RESET = 24'd500000;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ARM     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DISABLE = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HANDLER_MASK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REANCHOR     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARM_WR,
      ST_SCAN,
      ST_LOAD,
      ST_ANCHOR,
      ST_FIRE,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/cas_req_if.sv =====
interface cas_req_if;
   logic                            valid;
   logic                            ready;
   logic [cas_pkg::OPCODE_W-1:0]    opcode;
   logic [cas_pkg::STEP_W-1:0]      advance_us;
   logic [cas_pkg::INDEX_W-1:0]     alarm_index;
   logic [cas_pkg::TICKS_W-1:0]     interval_ticks;

   modport source (
      output valid, opcode, advance_us, alarm_index, interval_ticks,
      input  ready
   );

   modport sink (
      input  valid, opcode, advance_us, alarm_index, interval_ticks,
      output ready
   );
endinterface

// ===== hw/rtl/cas_rsp_if.sv =====
interface cas_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cas_pkg::ALARM_OUT_W-1:0]   fired_alarm;
   logic [cas_pkg::COUNT_W-1:0]       fire_count;
   logic                              last;

   modport source (
      output valid, fired_alarm, fire_count, last,
      input  ready
   );

   modport sink (
      input  valid, fired_alarm, fire_count, last,
      output ready
   );
endinterface

// ===== hw/rtl/cas_ram.sv =====
module cas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/cooperative_alarm_scheduler.sv =====
// Channel   Dir   Beat contents
// req_bus   in    opcode, advance_us, alarm_index, interval_ticks
// rsp_bus   out   fired_alarm, fire_count, last
// csr_*     in    csr_write, csr_index, csr_data (write only)
//
// A disable completes at acceptance; an arm multiplies at acceptance, then adds and writes.
// An advance adds the clamped step to the clock and scans the alarms in order; an
// armed alarm with a handler is read, re-anchored if it lags too far, fires while due
// (up to the fire cap, once for a one-shot) and is written back. Reset is synchronous
// and clears the clock, the armed flags and the control registers (re-anchor to default).
// The scan stalls only when the result register and the held beat are both full.
module cooperative_alarm_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   cas_req_if.sink                            req_bus,
   cas_rsp_if.source                          rsp_bus,
   input  logic                               csr_write,
   input  logic [cas_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NUM    = cas_pkg::NUM_ALARMS;
   localparam int IDX_W  = cas_pkg::IDX_W;
   localparam int SCAN_W = cas_pkg::SCAN_W;
   localparam int FIRE_W = cas_pkg::FIRE_W;
   localparam int TIME_W = cas_pkg::TIME_W;
   localparam int PER_W  = cas_pkg::PERIOD_W;

   cas_pkg::state_type state_ff, state_in;

   // Control and configuration registers.
   logic [TIME_W-1:0]                     now_ff, now_in;
   logic [NUM-1:0]                        armed_ff, armed_in;
   logic [cas_pkg::ALARM_COUNT_W-1:0]     count_ff, count_in;
   logic [cas_pkg::MASK_W-1:0]            mask_ff, mask_in;
   logic [cas_pkg::REANCHOR_W-1:0]        reanchor_ff, reanchor_in;
   logic [SCAN_W-1:0]                     scan_ff, scan_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [IDX_W-1:0]                      arm_ix_ff, arm_ix_in;
   logic [PER_W-1:0]                      prod_ff, prod_in;
   logic                                  once_ff, once_in;
   logic [TIME_W-1:0]                     dl_ff, dl_in;
   logic [PER_W-1:0]                      per_ff, per_in;
   logic [TIME_W-1:0]                     lag_ff, lag_in;
   logic                                  behind_ff, behind_in;
   logic [FIRE_W-1:0]                     fires_ff, fires_in;
   logic [cas_pkg::ALARM_OUT_W-1:0]       pend_alarm_ff, pend_alarm_in;
   logic [cas_pkg::COUNT_W-1:0]           pend_count_ff, pend_count_in;
   logic [cas_pkg::ALARM_OUT_W-1:0]       rsp_alarm_ff, rsp_alarm_in;
   logic [cas_pkg::COUNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                                  rsp_last_ff, rsp_last_in;

   // Table port signals.
   logic                                  ram_wr_en;
   logic [IDX_W-1:0]                      ram_wr_addr;
   logic [cas_pkg::ENTRY_W-1:0]           ram_wr_data;
   logic                                  ram_rd_en;
   logic [cas_pkg::ENTRY_W-1:0]           ram_rd_data;

   logic [IDX_W-1:0]                      scan_ix;
   logic [NUM-1:0]                        handler_vec;
   logic                                  req_exists;
   logic                                  scan_in_range;
   logic                                  out_free;
   logic [cas_pkg::STEP_W-1:0]            step_clamped;
   logic [TIME_W-1:0]                     rd_dl;
   logic [PER_W-1:0]                      rd_per;
   logic [cas_pkg::TICKS_W-1:0]           ticks_min1;
   logic [FIRE_W-1:0]                     fires_next;

   // Deadline and period of every alarm share one table entry.
   cas_ram #(
      .WIDTH (cas_pkg::ENTRY_W),
      .DEPTH (NUM)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ix),
      .rd_data (ram_rd_data)
   );

   assign scan_ix       = scan_ff[IDX_W-1:0];
   assign handler_vec   = NUM'(mask_ff);
   assign req_exists    = ({1'b0, req_bus.alarm_index} < count_ff) &&
                          (SCAN_W'(req_bus.alarm_index) < SCAN_W'(NUM));
   assign scan_in_range = (scan_ff < count_ff) && (scan_ff < SCAN_W'(NUM));
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign step_clamped  = (req_bus.advance_us > cas_pkg::STEP_CLAMP_US) ?
                          cas_pkg::STEP_CLAMP_US : req_bus.advance_us;
   assign rd_dl         = ram_rd_data[TIME_W-1:0];
   assign rd_per        = ram_rd_data[cas_pkg::ENTRY_W-1:TIME_W];
   assign ticks_min1    = (req_bus.interval_ticks == '0) ?
                          cas_pkg::TICKS_W'(1) : req_bus.interval_ticks;
   assign fires_next    = fires_ff + FIRE_W'(1);

   assign req_bus.ready       = (state_ff == cas_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.fired_alarm = rsp_alarm_ff;
   assign rsp_bus.fire_count  = rsp_count_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // Next state, datapath updates and table accesses.
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      armed_in      = armed_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      reanchor_in   = reanchor_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      arm_ix_in     = arm_ix_ff;
      prod_in       = prod_ff;
      once_in       = once_ff;
      dl_in         = dl_ff;
      per_in        = per_ff;
      lag_in        = lag_ff;
      behind_in     = behind_ff;
      fires_in      = fires_ff;
      pend_alarm_in = pend_alarm_ff;
      pend_count_in = pend_count_ff;
      rsp_alarm_in  = rsp_alarm_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = scan_ix;
      ram_wr_data   = {per_ff, dl_ff};
      ram_rd_en     = 1'b0;

      // The user must write configuration only while the block is idle; the block does not enforce this.
      if (csr_write) begin
         unique case (csr_index)
            cas_pkg::CSR_ALARM_COUNT:
               count_in = csr_data[cas_pkg::ALARM_COUNT_W-1:0];
            cas_pkg::CSR_HANDLER_MASK:
               mask_in = csr_data[cas_pkg::MASK_W-1:0];
            cas_pkg::CSR_REANCHOR:
               reanchor_in = csr_data[cas_pkg::REANCHOR_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         cas_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               unique case (req_bus.opcode)
                  cas_pkg::OP_ARM: begin
                     if (req_exists) begin
                        arm_ix_in = IDX_W'(req_bus.alarm_index);
                        prod_in   = PER_W'(ticks_min1) * PER_W'(cas_pkg::TICK_US);
                        once_in   = (req_bus.interval_ticks == '0);
                        state_in  = cas_pkg::ST_ARM_WR;
                     end
                  end
                  cas_pkg::OP_DISABLE: begin
                     if (req_exists) begin
                        armed_in[IDX_W'(req_bus.alarm_index)] = 1'b0;
                     end
                  end
                  cas_pkg::OP_ADVANCE: begin
                     if (req_bus.advance_us != '0) begin
                        now_in   = now_ff + TIME_W'(step_clamped);
                        scan_in  = '0;
                        state_in = cas_pkg::ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         cas_pkg::ST_ARM_WR: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = arm_ix_ff;
            ram_wr_data         = {(once_ff ? PER_W'(0) : prod_ff),
                                   now_ff + TIME_W'(prod_ff)};
            armed_in[arm_ix_ff] = 1'b1;
            state_in            = cas_pkg::ST_IDLE;
         end

         cas_pkg::ST_SCAN: begin
            if (!scan_in_range) begin
               state_in = cas_pkg::ST_DONE;
            end else if (armed_ff[scan_ix] && handler_vec[scan_ix]) begin
               ram_rd_en = 1'b1;
               state_in  = cas_pkg::ST_LOAD;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end

         // Table data is in; take the lag behind the deadline.
         cas_pkg::ST_LOAD: begin
            dl_in     = rd_dl;
            per_in    = rd_per;
            lag_in    = now_ff - rd_dl;
            behind_in = now_ff > rd_dl;
            fires_in  = '0;
            state_in  = cas_pkg::ST_ANCHOR;
         end

         // A periodic alarm that lags too far restarts one period from now.
         cas_pkg::ST_ANCHOR: begin
            if ((per_ff != '0) && behind_ff &&
                (lag_ff > TIME_W'(reanchor_ff))) begin
               dl_in = now_ff + TIME_W'(per_ff);
            end
            state_in = cas_pkg::ST_FIRE;
         end

         // One fire per cycle while the deadline is due, up to the fire cap; a one-shot fires once.
         cas_pkg::ST_FIRE: begin
            if (dl_ff <= now_ff) begin
               fires_in = fires_next;
               if (per_ff == '0) begin
                  armed_in[scan_ix] = 1'b0;
                  state_in          = cas_pkg::ST_WRITE;
               end else begin
                  dl_in = dl_ff + TIME_W'(per_ff);
                  if (fires_next >= FIRE_W'(cas_pkg::MAX_FIRES)) begin
                     state_in = cas_pkg::ST_WRITE;
                  end
               end
            end else begin
               state_in = cas_pkg::ST_WRITE;
            end
         end

         // Write the deadline back; after a fire, hand over the previous result and hold the new one.
         cas_pkg::ST_WRITE: begin
            ram_wr_en = 1'b1;
            if (fires_ff == '0) begin
               scan_in  = scan_ff + SCAN_W'(1);
               state_in = cas_pkg::ST_SCAN;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_alarm_in = pend_alarm_ff;
                  rsp_count_in = pend_count_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_alarm_in = cas_pkg::ALARM_OUT_W'(scan_ff);
               pend_count_in = cas_pkg::COUNT_W'(fires_ff);
               scan_in       = scan_ff + SCAN_W'(1);
               state_in      = cas_pkg::ST_SCAN;
            end
         end

         // The held result is the final one of this advance.
         cas_pkg::ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = cas_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_alarm_in  = pend_alarm_ff;
               rsp_count_in  = pend_count_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = cas_pkg::ST_IDLE;
            end
         end

         default: state_in = cas_pkg::ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         armed_ff      <= '0;
         count_ff      <= '0;
         mask_ff       <= '0;
         reanchor_ff   <= cas_pkg::REANCHOR_RESET;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         armed_ff      <= armed_in;
         count_ff      <= count_in;
         mask_ff       <= mask_in;
         reanchor_ff   <= reanchor_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers carry no reset.
   always_ff @(posedge clock) begin
      arm_ix_ff     <= arm_ix_in;
      prod_ff       <= prod_in;
      once_ff       <= once_in;
      dl_ff         <= dl_in;
      per_ff        <= per_in;
      lag_ff        <= lag_in;
      behind_ff     <= behind_in;
      fires_ff      <= fires_in;
      pend_alarm_ff <= pend_alarm_in;
      pend_count_ff <= pend_count_in;
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;

   // Opcode 3 is not assigned to any operation.
   localparam logic [cas_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Cycles to let the block finish an advance that produced no result beat.
   localparam int SETTLE_CYCLES = 400;
   // Cycles without any beat or register write before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   // Length of the long receiver hold-off.
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [cas_pkg::ALARM_OUT_W-1:0] fired_alarm;
      logic [cas_pkg::COUNT_W-1:0]     fire_count;
      logic                            last;
   } fire_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [cas_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cas_pkg::CSR_DATA_W-1:0]  csr_data;

   cas_req_if req_bus ();
   cas_rsp_if rsp_bus ();

   cooperative_alarm_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the alarm table and the registers.
   logic [cas_pkg::TIME_W-1:0]        clock_now;
   logic [cas_pkg::TIME_W-1:0]        deadline_tab [cas_pkg::NUM_ALARMS];
   logic [cas_pkg::PERIOD_W-1:0]      period_tab [cas_pkg::NUM_ALARMS];
   logic [cas_pkg::NUM_ALARMS-1:0]    armed_tab;
   logic [cas_pkg::ALARM_COUNT_W-1:0] cfg_alarm_count;
   logic [cas_pkg::MASK_W-1:0]        cfg_handler_mask;
   logic [cas_pkg::REANCHOR_W-1:0]    cfg_reanchor;

   fire_type expected_fires [$];
   fire_type fire_want;
   int       failures = 0;
   int       quiet_cycles = 0;
   int       stall_request = 0;
   int       stall_len;
   bit       send_gaps = 1'b1;
   bit       take_gaps = 1'b1;

   always #2 clock = ~clock;

   function automatic bit alarm_created(int unsigned a);
      return a < cfg_alarm_count && a < cas_pkg::NUM_ALARMS;
   endfunction

   // Apply one accepted command beat to the shadow table and queue its fires.
   function automatic void predict_cmd(logic [cas_pkg::OPCODE_W-1:0] op,
                                       logic [cas_pkg::STEP_W-1:0] step,
                                       logic [cas_pkg::INDEX_W-1:0] idx,
                                       logic [cas_pkg::TICKS_W-1:0] ticks);
      fire_type                   batch [$];
      logic [cas_pkg::STEP_W-1:0] clamped;
      int unsigned                fires;
      int unsigned                a;
      if (op == cas_pkg::OP_ARM) begin
         if (alarm_created(idx)) begin
            period_tab[idx]   = cas_pkg::PERIOD_W'(ticks) *
                                cas_pkg::PERIOD_W'(cas_pkg::TICK_US);
            deadline_tab[idx] = clock_now +
                                cas_pkg::TIME_W'((ticks == 0) ? 16'd1 : ticks) *
                                cas_pkg::TIME_W'(cas_pkg::TICK_US);
            armed_tab[idx]    = 1'b1;
         end
      end else if (op == cas_pkg::OP_DISABLE) begin
         if (alarm_created(idx))
            armed_tab[idx] = 1'b0;
      end else if (op == cas_pkg::OP_ADVANCE && step != 0) begin
         clamped   = (step > cas_pkg::STEP_CLAMP_US) ? cas_pkg::STEP_CLAMP_US : step;
         clock_now = clock_now + cas_pkg::TIME_W'(clamped);
         for (a = 0; alarm_created(a); a++) begin
            if (!armed_tab[a] || !cfg_handler_mask[a])
               continue;
            // A periodic alarm that lags too far restarts one period from now.
            if (period_tab[a] != 0 && clock_now > deadline_tab[a] &&
                clock_now - deadline_tab[a] > cas_pkg::TIME_W'(cfg_reanchor))
               deadline_tab[a] = clock_now + cas_pkg::TIME_W'(period_tab[a]);
            fires = 0;
            while (armed_tab[a] && deadline_tab[a] <= clock_now) begin
               fires++;
               if (period_tab[a] == 0) begin
                  armed_tab[a] = 1'b0;
                  break;
               end
               deadline_tab[a] = deadline_tab[a] + cas_pkg::TIME_W'(period_tab[a]);
               if (fires >= cas_pkg::MAX_FIRES)
                  break;
            end
            if (fires > 0)
               batch.push_back('{fired_alarm: cas_pkg::ALARM_OUT_W'(a),
                                 fire_count: cas_pkg::COUNT_W'(fires), last: 1'b0});
         end
         if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
         foreach (batch[k])
            expected_fires.push_back(batch[k]);
      end
   endfunction

   // Offer one command beat, idling first at random, and wait until it is taken.
   task automatic send_cmd(input logic [cas_pkg::OPCODE_W-1:0] op,
                           input logic [cas_pkg::STEP_W-1:0] step,
                           input logic [cas_pkg::INDEX_W-1:0] idx,
                           input logic [cas_pkg::TICKS_W-1:0] ticks);
      while (send_gaps && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= op;
      req_bus.advance_us     <= step;
      req_bus.alarm_index    <= idx;
      req_bus.interval_ticks <= ticks;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_cmd(op, step, idx, ticks);
   endtask

   // Stop offering, wait for every expected result beat, then let the block settle.
   task automatic quiesce(input int settle);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_fires.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [cas_pkg::CSR_INDEX_W-1:0] index,
                            input logic [cas_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      if (index == cas_pkg::CSR_ALARM_COUNT)
         cfg_alarm_count = data[cas_pkg::ALARM_COUNT_W-1:0];
      else if (index == cas_pkg::CSR_HANDLER_MASK)
         cfg_handler_mask = data[cas_pkg::MASK_W-1:0];
      else if (index == cas_pkg::CSR_REANCHOR)
         cfg_reanchor = data[cas_pkg::REANCHOR_W-1:0];
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned count, input int unsigned mask,
                            input int unsigned reanchor);
      quiesce(SETTLE_CYCLES);
      write_csr(cas_pkg::CSR_ALARM_COUNT, cas_pkg::CSR_DATA_W'(count));
      write_csr(cas_pkg::CSR_HANDLER_MASK, cas_pkg::CSR_DATA_W'(mask));
      write_csr(cas_pkg::CSR_REANCHOR, cas_pkg::CSR_DATA_W'(reanchor));
   endtask

   // Random command: mostly short advances and short periods so that alarms fire often.
   task automatic send_random_cmd();
      int unsigned                 pick;
      int unsigned                 shape;
      logic [cas_pkg::STEP_W-1:0]  step;
      logic [cas_pkg::TICKS_W-1:0] ticks;
      pick  = $urandom_range(99);
      shape = $urandom_range(99);
      step  = cas_pkg::STEP_W'($urandom);
      ticks = cas_pkg::TICKS_W'($urandom);
      if (pick < 55) begin
         if (shape < 75)
            step = cas_pkg::STEP_W'($urandom_range(1, 50000));
         else if (shape < 90)
            step = cas_pkg::STEP_W'($urandom_range(50001, 1000000));
         else if (shape < 97)
            step = cas_pkg::STEP_W'($urandom_range(1000001, 24'hFFFFFF));
         else
            step = '0;
         send_cmd(cas_pkg::OP_ADVANCE, step, cas_pkg::INDEX_W'($urandom), ticks);
      end else if (pick < 85) begin
         if (shape < 80)
            ticks = cas_pkg::TICKS_W'($urandom_range(0, 6));
         send_cmd(cas_pkg::OP_ARM, step, cas_pkg::INDEX_W'($urandom), ticks);
      end else if (pick < 95) begin
         send_cmd(cas_pkg::OP_DISABLE, step, cas_pkg::INDEX_W'($urandom), ticks);
      end else begin
         send_cmd(OP_UNUSED, step, cas_pkg::INDEX_W'($urandom), ticks);
      end
   endtask

   // With the reset registers no alarm exists, so nothing can be armed or fire.
   task automatic test_reset_state();
      send_cmd(cas_pkg::OP_ARM, '0, 4'd0, 16'd0);
      send_cmd(cas_pkg::OP_DISABLE, '0, 4'd15, 16'd0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd10000, 4'd0, 16'd0);
   endtask

   // One-shot, periodic, widest period, zero and clamped steps, unused opcode, disable, fire cap, re-anchor.
   task automatic test_directed_ops();
      configure(16, 16'hFFFF, 500000);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd0, 16'd0);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd1, 16'd1);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd15, 16'hFFFF);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd2, 16'd3);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd0, 4'd0, 16'd0);
      send_cmd(OP_UNUSED, 24'hFFFFFF, 4'hF, 16'hFFFF);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd10000, 4'd0, 16'd0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd400000, 4'd0, 16'd0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'hFFFFFF, 4'd0, 16'd0);
      send_cmd(cas_pkg::OP_DISABLE, '0, 4'd1, 16'd0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd30000, 4'd0, 16'd0);
   endtask

   // Alarms beyond the count are untouched, alarms without a handler are skipped,
   // and raising the count again exposes hidden alarms as they were.
   task automatic test_index_and_handler();
      configure(4, 16'hFFF5, 500000);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd9, 16'd1);
      send_cmd(cas_pkg::OP_DISABLE, '0, 4'd12, 16'd0);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd3, 16'd2);
      send_cmd(cas_pkg::OP_ARM, '0, 4'd2, 16'd0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd30000, 4'd0, 16'd0);
      configure(16, 16'hFFFF, 500000);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd20000, 4'd0, 16'd0);
   endtask

   // The receiver holds off while advances keep coming, so the block must stall its
   // input; afterwards the sender waits for every result beat before going on.
   task automatic test_backpressure();
      int k;
      configure(16, 16'hFFFF, 500000);
      for (k = 0; k < cas_pkg::NUM_ALARMS; k++)
         send_cmd(cas_pkg::OP_ARM, '0, cas_pkg::INDEX_W'(k), 16'd1);
      stall_request = HOLD_OFF_CYCLES;
      repeat (5) send_cmd(cas_pkg::OP_ADVANCE, 24'd200000, 4'd0, 16'd0);
      quiesce(0);
      send_cmd(cas_pkg::OP_ADVANCE, 24'd10000, 4'd0, 16'd0);
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned mask,
                            input int unsigned reanchor, input int items, input bit gaps,
                            input bit pause_midway);
      int n;
      configure(count, mask, reanchor);
      send_gaps = gaps;
      take_gaps = gaps;
      for (n = 0; n < items; n++) begin
         if (pause_midway && n == items / 2)
            quiesce(0);
         send_random_cmd();
      end
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   // Random commands under a range of register settings, extremes included.
   task automatic test_random_phases();
      run_phase(16, 16'hFFFF, 500000, 50, 1'b1, 1'b1);
      run_phase(16, $urandom_range(0, 16'hFFFF), 0, 30, 1'b1, 1'b0);
      run_phase(8, 16'hFFFF, 24'hFFFFFF, 30, 1'b0, 1'b0);
      run_phase(31, 16'hFFFF, $urandom_range(0, 24'hFFFFFF), 30, 1'b1, 1'b0);
      run_phase(1, 16'h0001, 200000, 15, 1'b1, 1'b0);
      run_phase(16, 16'h0000, 500000, 10, 1'b1, 1'b0);
      run_phase(16, 16'hFFFF, 500000, 40, 1'b1, 1'b1);
   endtask

   // Result receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request != 0) begin
            stall_len     = stall_request;
            stall_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (stall_len - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(take_gaps && $urandom_range(99) < 22);
         end
      end
   end

   // Compare each accepted result beat with the oldest expected fire.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_fires.size() == 0) begin
            $error("result beat with none expected: fired_alarm %0d fire_count %0d last %0d",
                   rsp_bus.fired_alarm, rsp_bus.fire_count, rsp_bus.last);
            failures++;
         end else begin
            fire_want = expected_fires.pop_front();
            if (rsp_bus.fired_alarm !== fire_want.fired_alarm) begin
               $error("fired_alarm: expected %0d, got %0d",
                      fire_want.fired_alarm, rsp_bus.fired_alarm);
               failures++;
            end
            if (rsp_bus.fire_count !== fire_want.fire_count) begin
               $error("fire_count: expected %0d, got %0d",
                      fire_want.fire_count, rsp_bus.fire_count);
               failures++;
            end
            if (rsp_bus.last !== fire_want.last) begin
               $error("last: expected %0d, got %0d", fire_want.last, rsp_bus.last);
               failures++;
            end
         end
      end
   end

   // Watchdog: give up when nothing has moved for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_write)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      reset                  <= 1'b1;
      csr_write              <= 1'b0;
      csr_index              <= '0;
      csr_data               <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.opcode         <= '0;
      req_bus.advance_us     <= '0;
      req_bus.alarm_index    <= '0;
      req_bus.interval_ticks <= '0;
      clock_now        = '0;
      armed_tab        = '0;
      cfg_alarm_count  = '0;
      cfg_handler_mask = '0;
      cfg_reanchor     = cas_pkg::REANCHOR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_ops();
      test_index_and_handler();
      test_backpressure();
      test_random_phases();
      quiesce(SETTLE_CYCLES);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
